/* sv/smacd_pkg.sv */
package smacd_pkg;

   // Widths of the item fields on the ports.
   localparam int IN_DATA_W  = 32;
   localparam int AVG_W      = 32;
   localparam int OUT_DATA_W = 72;
   localparam int OUT_PAD_W  = OUT_DATA_W - 2 * AVG_W - 2;

   // Configuration registers.
   localparam int CSR_ADDR_W = 1;
   localparam int LEN_W      = 9;

   localparam logic [CSR_ADDR_W-1:0] REG_FAST_LENGTH = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_SLOW_LENGTH = 1'b1;

   localparam logic [LEN_W-1:0] FAST_LENGTH_RESET = 9'd10;
   localparam logic [LEN_W-1:0] SLOW_LENGTH_RESET = 9'd30;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_SUM,
      S_DIV_FAST,
      S_DIV_SLOW,
      S_RESULT
   } smacd_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } smacd_div_status_type;

endpackage

/* sv/sma_crossover_detector.sv */
// Moving average crossover detector.
// One closing price enters per item on the req_ stream (unsigned, 8 fraction
// bits). For each item one result leaves on the rsp_ stream: the fast and the
// slow simple moving average over the newest fast_length / slow_length closes
// (fewer while the history is still short), truncated, and flags that mark a
// crossover or a crossunder of the fast average against the slow one.
// The window lengths are written through csr_ (index 0 fast, 1 slow); a
// length of 0 acts as 1 and a length above MAX_WINDOW acts as MAX_WINDOW.
// An accepted item passes through the states setup, sum, fast division, slow
// division and result before rsp_tvalid. The history memory is read once per
// cycle, newest entry first, to form both sums in one pass over the newest n
// entries, where n is the larger of the two clipped lengths, and a single
// one-bit-per-cycle divider forms the two averages one after the other.
// req_tready is high only while no item is in work, so a new item is not
// accepted before the last one has left the result state.
// A finished result sits in an output register; while the receiver stalls,
// a new item can be accepted and worked on, and it waits for the register.
// Reset clears the history count, the previous averages and the output valid
// flag, and sets the lengths to 10 and 30.
module sma_crossover_detector #(
   parameter int MAX_WINDOW = 256,
   parameter int PRICE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [31:0] close_price
   input  logic [smacd_pkg::IN_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] fast_average, [63:32] slow_average, [64] cross_over,
   // [65] cross_under, [71:66] zero
   output logic [smacd_pkg::OUT_DATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_we,
   input  logic [smacd_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [smacd_pkg::LEN_W-1:0]          csr_wdata
);

   localparam int PTR_W = $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = PRICE_BITS + PTR_W;
   localparam int CMP_W = (CNT_W > smacd_pkg::LEN_W) ? CNT_W : smacd_pkg::LEN_W;
   localparam int EXT_W = (PRICE_BITS > smacd_pkg::IN_DATA_W) ?
                          PRICE_BITS : smacd_pkg::IN_DATA_W;

   smacd_pkg::smacd_state_type state_ff, state_in;

   logic [smacd_pkg::LEN_W-1:0] fast_len_ff, fast_len_in;
   logic [smacd_pkg::LEN_W-1:0] slow_len_ff, slow_len_in;
   logic [PTR_W-1:0]            wpos_ff, wpos_in;
   logic [PTR_W-1:0]            newest_ff, newest_in;
   logic [CNT_W-1:0]            seen_ff, seen_in;
   logic                        have_prev_ff, have_prev_in;
   logic [CNT_W-1:0]            fn_ff, fn_in;
   logic [CNT_W-1:0]            sn_ff, sn_in;
   logic [PRICE_BITS-1:0]       fast_avg_ff, fast_avg_in;
   logic [PRICE_BITS-1:0]       slow_avg_ff, slow_avg_in;
   logic [PRICE_BITS-1:0]       prev_fast_ff, prev_fast_in;
   logic [PRICE_BITS-1:0]       prev_slow_ff, prev_slow_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [smacd_pkg::OUT_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic [EXT_W-1:0]      price_ext;
   logic [PRICE_BITS-1:0] price;
   logic [CNT_W-1:0]      fl_clamp, sl_clamp;
   logic [CNT_W-1:0]      fn_c, sn_c;
   logic                  sweep_start;
   logic                  sweep_done;
   logic [SUM_W-1:0]      fast_sum, slow_sum;
   logic                  div_start;
   logic [SUM_W-1:0]      div_dividend;
   logic [CNT_W-1:0]      div_divisor;
   logic [SUM_W-1:0]      div_quotient;
   smacd_pkg::smacd_div_status_type div_status;
   logic                  over, under;
   logic [EXT_W-1:0]      fast_out_ext, slow_out_ext;

   function automatic logic [CNT_W-1:0] clamp_len(input logic [smacd_pkg::LEN_W-1:0] len);
      logic [CMP_W-1:0] len_ext;
      len_ext = CMP_W'(len);
      if (len == '0) begin
         return CNT_W'(1);
      end else if (len_ext > CMP_W'(MAX_WINDOW)) begin
         return CNT_W'(MAX_WINDOW);
      end
      return len_ext[CNT_W-1:0];
   endfunction

   assign accept    = req_tvalid && req_tready;
   assign price_ext = EXT_W'(req_tdata);
   assign price     = price_ext[PRICE_BITS-1:0];

   assign fl_clamp = clamp_len(fast_len_ff);
   assign sl_clamp = clamp_len(slow_len_ff);
   assign fn_c     = (fl_clamp < seen_ff) ? fl_clamp : seen_ff;
   assign sn_c     = (sl_clamp < seen_ff) ? sl_clamp : seen_ff;

   // Flags compare the full-width averages, not the truncated outputs.
   assign over  = have_prev_ff && (fast_avg_ff > slow_avg_ff) && (prev_fast_ff < prev_slow_ff);
   assign under = have_prev_ff && (fast_avg_ff < slow_avg_ff) && (prev_fast_ff > prev_slow_ff);

   assign fast_out_ext = EXT_W'(fast_avg_ff);
   assign slow_out_ext = EXT_W'(slow_avg_ff);

   always_comb begin
      state_in     = state_ff;
      fast_len_in  = fast_len_ff;
      slow_len_in  = slow_len_ff;
      wpos_in      = wpos_ff;
      newest_in    = newest_ff;
      seen_in      = seen_ff;
      have_prev_in = have_prev_ff;
      fn_in        = fn_ff;
      sn_in        = sn_ff;
      fast_avg_in  = fast_avg_ff;
      slow_avg_in  = slow_avg_ff;
      prev_fast_in = prev_fast_ff;
      prev_slow_in = prev_slow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      sweep_start  = 1'b0;
      div_start    = 1'b0;
      div_dividend = fast_sum;
      div_divisor  = fn_ff;

      if (csr_we) begin
         unique case (csr_addr)
            smacd_pkg::REG_FAST_LENGTH: fast_len_in = csr_wdata;
            smacd_pkg::REG_SLOW_LENGTH: slow_len_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         smacd_pkg::S_IDLE: begin
            if (accept) begin
               newest_in    = wpos_ff;
               wpos_in      = (wpos_ff == PTR_W'(MAX_WINDOW - 1)) ? '0 : wpos_ff + PTR_W'(1);
               have_prev_in = (seen_ff != '0);
               if (seen_ff != CNT_W'(MAX_WINDOW)) begin
                  seen_in = seen_ff + CNT_W'(1);
               end
               state_in = smacd_pkg::S_SETUP;
            end
         end
         smacd_pkg::S_SETUP: begin
            fn_in       = fn_c;
            sn_in       = sn_c;
            sweep_start = 1'b1;
            state_in    = smacd_pkg::S_SUM;
         end
         smacd_pkg::S_SUM: begin
            if (sweep_done) begin
               div_start = 1'b1;
               state_in  = smacd_pkg::S_DIV_FAST;
            end
         end
         smacd_pkg::S_DIV_FAST: begin
            div_dividend = slow_sum;
            div_divisor  = sn_ff;
            if (div_status.done) begin
               fast_avg_in = div_quotient[PRICE_BITS-1:0];
               div_start   = 1'b1;
               state_in    = smacd_pkg::S_DIV_SLOW;
            end
         end
         smacd_pkg::S_DIV_SLOW: begin
            if (div_status.done) begin
               slow_avg_in = div_quotient[PRICE_BITS-1:0];
               state_in    = smacd_pkg::S_RESULT;
            end
         end
         smacd_pkg::S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{smacd_pkg::OUT_PAD_W{1'b0}}, under, over,
                               slow_out_ext[smacd_pkg::AVG_W-1:0],
                               fast_out_ext[smacd_pkg::AVG_W-1:0]};
               prev_fast_in = fast_avg_ff;
               prev_slow_in = slow_avg_ff;
               state_in     = smacd_pkg::S_IDLE;
            end
         end
         default: state_in = smacd_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smacd_pkg::S_IDLE;
         fast_len_ff  <= smacd_pkg::FAST_LENGTH_RESET;
         slow_len_ff  <= smacd_pkg::SLOW_LENGTH_RESET;
         wpos_ff      <= '0;
         seen_ff      <= '0;
         have_prev_ff <= 1'b0;
         prev_fast_ff <= '0;
         prev_slow_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fast_len_ff  <= fast_len_in;
         slow_len_ff  <= slow_len_in;
         wpos_ff      <= wpos_in;
         seen_ff      <= seen_in;
         have_prev_ff <= have_prev_in;
         prev_fast_ff <= prev_fast_in;
         prev_slow_ff <= prev_slow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      newest_ff   <= newest_in;
      fn_ff       <= fn_in;
      sn_ff       <= sn_in;
      fast_avg_ff <= fast_avg_in;
      slow_avg_ff <= slow_avg_in;
      rsp_data_ff <= rsp_data_in;
   end

   smacd_window #(
      .DEPTH  (MAX_WINDOW),
      .DATA_W (PRICE_BITS),
      .SUM_W  (SUM_W)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (accept),
      .wr_addr     (wpos_ff),
      .wr_data     (price),
      .sweep_start (sweep_start),
      .newest_addr (newest_ff),
      .fast_n      (fn_c),
      .slow_n      (sn_c),
      .fast_sum    (fast_sum),
      .slow_sum    (slow_sum),
      .sweep_done  (sweep_done)
   );

   smacd_divider #(
      .SUM_W (SUM_W),
      .DIV_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   assign req_tready = (state_ff == smacd_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNT_W'(MAX_WINDOW))
      else $error("history count exceeds the window depth");

   a_counts_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == smacd_pkg::S_SUM |->
         fn_ff != '0 && sn_ff != '0 && fn_ff <= seen_ff && sn_ff <= seen_ff)
      else $error("average count outside the stored history");

   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   a_sweep_done_in_sum: assert property (@(posedge clock) disable iff (reset)
      sweep_done |-> state_ff == smacd_pkg::S_SUM)
      else $error("window sweep finished outside the summing phase");

   a_accept_to_setup: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == smacd_pkg::S_SETUP && $past(wpos_ff) == newest_ff)
      else $error("accepted item did not start its sweep at the written entry");

endmodule

/* sv/smacd_window.sv */
module smacd_window #(
   parameter int DEPTH  = 256,
   parameter int DATA_W = 32,
   parameter int SUM_W  = 40
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_W-1:0]          wr_data,
   input  logic                       sweep_start,
   input  logic [$clog2(DEPTH)-1:0]   newest_addr,
   input  logic [$clog2(DEPTH+1)-1:0] fast_n,
   input  logic [$clog2(DEPTH+1)-1:0] slow_n,
   output logic [SUM_W-1:0]           fast_sum,
   output logic [SUM_W-1:0]           slow_sum,
   output logic                       sweep_done
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   logic [PTR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] kd_ff, kd_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] fast_n_ff, fast_n_in;
   logic [CNT_W-1:0] slow_n_ff, slow_n_in;
   logic [SUM_W-1:0] fast_acc_ff, fast_acc_in;
   logic [SUM_W-1:0] slow_acc_ff, slow_acc_in;
   logic             active_ff, active_in;
   logic             pend_ff, pend_in;
   logic             done_ff, done_in;

   // One read per cycle, newest entry first; the read data is registered and arrives in the cycle after its address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr_ff];
   end

   always_comb begin
      rd_addr_in  = rd_addr_ff;
      k_in        = k_ff;
      kd_in       = k_ff;
      total_in    = total_ff;
      fast_n_in   = fast_n_ff;
      slow_n_in   = slow_n_ff;
      fast_acc_in = fast_acc_ff;
      slow_acc_in = slow_acc_ff;
      active_in   = active_ff;
      pend_in     = active_ff;
      done_in     = pend_ff && !active_ff;

      if (pend_ff) begin
         if (kd_ff < fast_n_ff) begin
            fast_acc_in = fast_acc_ff + SUM_W'(rd_data_ff);
         end
         if (kd_ff < slow_n_ff) begin
            slow_acc_in = slow_acc_ff + SUM_W'(rd_data_ff);
         end
      end

      if (sweep_start) begin
         rd_addr_in  = newest_addr;
         k_in        = '0;
         total_in    = (fast_n > slow_n) ? fast_n : slow_n;
         fast_n_in   = fast_n;
         slow_n_in   = slow_n;
         fast_acc_in = '0;
         slow_acc_in = '0;
         active_in   = 1'b1;
      end else if (active_ff) begin
         k_in       = k_ff + CNT_W'(1);
         rd_addr_in = (rd_addr_ff == '0) ? PTR_W'(DEPTH - 1) : rd_addr_ff - PTR_W'(1);
         if (k_ff == total_ff - CNT_W'(1)) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      k_ff        <= k_in;
      kd_ff       <= kd_in;
      total_ff    <= total_in;
      fast_n_ff   <= fast_n_in;
      slow_n_ff   <= slow_n_in;
      fast_acc_ff <= fast_acc_in;
      slow_acc_ff <= slow_acc_in;
   end

   assign fast_sum   = fast_acc_ff;
   assign slow_sum   = slow_acc_ff;
   assign sweep_done = done_ff;

endmodule

/* sv/smacd_divider.sv */
module smacd_divider #(
   parameter int SUM_W = 40,
   parameter int DIV_W = 9
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [SUM_W-1:0]               dividend,
   input  logic [DIV_W-1:0]               divisor,
   output logic [SUM_W-1:0]               quotient,
   output smacd_pkg::smacd_div_status_type status
);

   localparam int CW = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DIV_W:0] rem_sh;
   logic [DIV_W:0] diff;
   logic           ge;

   // Restoring division, one quotient bit per cycle. Quotient bits shift in
   // from the bottom of the dividend register as its bits move out the top.
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[SUM_W-1]};
      ge     = rem_sh >= {1'b0, dsr_ff};
      diff   = rem_sh - {1'b0, dsr_ff};

      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[SUM_W-2:0], ge};
         rem_in = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign quotient    = dvd_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
